// ----- design/ceil_mul_div_saturating_assert.svh -----
// Assertion macros for the ceiling mul-div block.
// Used by the port checker; needs nothing else.
`ifndef CEIL_MUL_DIV_SATURATING_ASSERT_SVH
`define CEIL_MUL_DIV_SATURATING_ASSERT_SVH

// implication checked at every clock edge outside reset
`define CMDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// implication whose consequent is checked in the cycle after the antecedent
`define CMDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// ----- design/cmds_pkg.sv -----
// Shared constants for the ceiling mul-div block.
// No dependencies.
`default_nettype none
package cmds_pkg;
    localparam int FIELD_W        = 64;
    localparam int DATA_WIDTH_DEF = 64;
    localparam int ADDR_W         = 4;
    localparam logic [ADDR_W-1:0] ADDR_MULTIPLIER = 4'h0;
    localparam logic [FIELD_W-1:0] MULT_RESET = 64'd1;
endpackage
`default_nettype wire

// ----- design/ceil_mul_div_saturating.sv -----
// Top level of the ceiling mul-div block: multiplier, restoring divider pipeline, APB register.
// Depends on cmds_pkg.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------------
//  in      | sink      | in_valid / in_stall | value, divisor
//  out     | source    | out_valid/out_stall | quotient, saturated, divide_by_zero
//  cfg     | APB slave | psel/penable/pready | multiplier at byte address 0
//
// One transaction enters per cycle while in_stall is low. The stages, in order, are
// stage A (half-width partial products), stage B (their sum), divider entry 0 (load),
// one divider entry per quotient bit, and the output register (rounding and saturation).
// The whole pipeline advances together; a stall on the output holds every stage, and
// in_stall rises only while the output register is full and stalled.
// Reset clears all valid bits and sets the multiplier to 1.
`default_nettype none
module ceil_mul_div_saturating #(
    parameter int DATA_WIDTH = cmds_pkg::DATA_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [cmds_pkg::FIELD_W-1:0] value,
    input  logic [cmds_pkg::FIELD_W-1:0] divisor,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [cmds_pkg::FIELD_W-1:0] quotient,
    output logic                        saturated,
    output logic                        divide_by_zero,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cmds_pkg::ADDR_W-1:0] paddr,
    input  logic [cmds_pkg::FIELD_W-1:0] pwdata,
    output logic [cmds_pkg::FIELD_W-1:0] prdata,
    output logic                        pready
);
    import cmds_pkg::*;

    localparam int W = DATA_WIDTH;
    localparam int H = (W + 1) / 2;

    // configuration register
    logic [FIELD_W-1:0] mult_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MULTIPLIER) ? mult_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg <= MULT_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr == ADDR_MULTIPLIER)
        begin
            mult_reg <= pwdata;
        end
    end

    // advance the whole pipeline unless the output holds a stalled transaction
    logic adv;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // stage A: four half-width partial products
    logic [2*H-1:0] xv, xm;
    assign xv = (2*H)'(value[W-1:0]);
    assign xm = (2*H)'(mult_reg[W-1:0]);

    logic           a_vld_reg;
    logic [2*H-1:0] a_ll_reg, a_lh_reg, a_hl_reg, a_hh_reg;
    logic [W-1:0]   a_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_ll_reg <= xv[H-1:0]   * xm[H-1:0];
            a_lh_reg <= xv[H-1:0]   * xm[2*H-1:H];
            a_hl_reg <= xv[2*H-1:H] * xm[H-1:0];
            a_hh_reg <= xv[2*H-1:H] * xm[2*H-1:H];
            a_d_reg  <= divisor[W-1:0];
        end
    end

    // stage B: sum the partial products into the full double-width product
    logic [4*H-1:0] prod_full;
    assign prod_full = (4*H)'(a_ll_reg)
                     + ((4*H)'(a_lh_reg) << H)
                     + ((4*H)'(a_hl_reg) << H)
                     + ((4*H)'(a_hh_reg) << (2*H));

    logic           b_vld_reg;
    logic [2*W-1:0] b_prod_reg;
    logic [W-1:0]   b_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_prod_reg <= prod_full[2*W-1:0];
            b_d_reg    <= a_d_reg;
        end
    end

    // divider chain: entry 0 is loaded from the product, each later entry resolves
    // one quotient bit. The quotient bits shift in as the dividend bits shift out.
    // A high half at or above the divisor means the quotient overflows W bits.
    logic         dv_vld_reg [0:W];
    logic [W-1:0] dv_rem_reg [0:W];
    logic [W-1:0] dv_nq_reg  [0:W];
    logic [W-1:0] dv_d_reg   [0:W];
    logic         dv_sat_reg [0:W];
    logic         dv_dz_reg  [0:W];

    logic [W-1:0] dv_rem_next [0:W-1];
    logic [W-1:0] dv_nq_next  [0:W-1];

    always_comb
    begin
        for (int k = 0; k < W; k++)
        begin
            logic [W:0] trial;
            logic       ge;
            trial = {dv_rem_reg[k], dv_nq_reg[k][W-1]};
            ge    = trial >= {1'b0, dv_d_reg[k]};
            dv_rem_next[k] = ge ? W'(trial - {1'b0, dv_d_reg[k]}) : trial[W-1:0];
            dv_nq_next[k]  = {dv_nq_reg[k][W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= W; k++)
            begin
                dv_vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            dv_vld_reg[0] <= b_vld_reg;
            for (int k = 0; k < W; k++)
            begin
                dv_vld_reg[k+1] <= dv_vld_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_rem_reg[0] <= b_prod_reg[2*W-1:W];
            dv_nq_reg[0]  <= b_prod_reg[W-1:0];
            dv_d_reg[0]   <= b_d_reg;
            dv_sat_reg[0] <= b_prod_reg[2*W-1:W] >= b_d_reg;
            dv_dz_reg[0]  <= b_d_reg == '0;
            for (int k = 0; k < W; k++)
            begin
                dv_rem_reg[k+1] <= dv_rem_next[k];
                dv_nq_reg[k+1]  <= dv_nq_next[k];
                dv_d_reg[k+1]   <= dv_d_reg[k];
                dv_sat_reg[k+1] <= dv_sat_reg[k];
                dv_dz_reg[k+1]  <= dv_dz_reg[k];
            end
        end
    end

    // final stage: round up on a nonzero remainder, saturate on overflow, zero result on a zero divisor
    logic         f_round, f_sat;
    logic [W-1:0] f_q;

    always_comb
    begin
        f_round = dv_rem_reg[W] != '0;
        f_sat   = dv_sat_reg[W] || (f_round && dv_nq_reg[W] == '1);
        f_q     = dv_nq_reg[W] + W'(f_round);
    end

    logic               out_vld_reg;
    logic [FIELD_W-1:0] q_reg;
    logic               sat_reg, dz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= dv_vld_reg[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (dv_dz_reg[W])
            begin
                q_reg   <= '0;
                sat_reg <= 1'b0;
                dz_reg  <= 1'b1;
            end
            else
            begin
                q_reg   <= FIELD_W'(f_sat ? {W{1'b1}} : f_q);
                sat_reg <= f_sat;
                dz_reg  <= 1'b0;
            end
        end
    end

    assign out_valid      = out_vld_reg;
    assign quotient       = q_reg;
    assign saturated      = sat_reg;
    assign divide_by_zero = dz_reg;
endmodule
`default_nettype wire

// ----- design/cmds_checker.sv -----
// Port checker for the ceiling mul-div block, bound to the top level.
// Depends on cmds_pkg and ceil_mul_div_saturating_assert.svh.
`default_nettype none
`include "ceil_mul_div_saturating_assert.svh"
module cmds_checker #(
    parameter int DATA_WIDTH = cmds_pkg::DATA_WIDTH_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [cmds_pkg::FIELD_W-1:0] quotient,
    input logic                         saturated,
    input logic                         divide_by_zero
);
    import cmds_pkg::*;

    // a zero divisor forces a clean zero result
    `CMDS_ASSERT_IMP(dz_zero_q, clk, rst_n, out_valid && divide_by_zero,
        quotient == '0 && !saturated)
    // saturation shows as all ones in the used width
    `CMDS_ASSERT_IMP(sat_all_ones, clk, rst_n, out_valid && saturated,
        quotient == FIELD_W'({DATA_WIDTH{1'b1}}))
    // the input is only held back by a full, stalled output
    `CMDS_ASSERT_IMP(stall_cause, clk, rst_n, in_stall, out_valid && out_stall)
    // a stalled result stays in place
    `CMDS_ASSERT_NEXT(out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(quotient))
endmodule

bind ceil_mul_div_saturating cmds_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cmds_checker (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
    .out_stall(out_stall), .quotient(quotient), .saturated(saturated),
    .divide_by_zero(divide_by_zero)
);
`default_nettype wire

// ----- tb/tb_ceil_mul_div_saturating.sv -----
// Testbench for ceil_mul_div_saturating: drives value/divisor transactions and APB
// multiplier writes, predicts each quotient and checks it. Depends on cmds_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_ceil_mul_div_saturating;
    import cmds_pkg::*;

    localparam int W       = DATA_WIDTH_DEF;
    localparam int LATENCY = W + 4;

    typedef struct packed {
        logic [FIELD_W-1:0] quotient;
        logic               saturated;
        logic               divide_by_zero;
    } quot_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [FIELD_W-1:0] value;
    logic [FIELD_W-1:0] divisor;
    logic               out_valid;
    logic               out_stall;
    logic [FIELD_W-1:0] quotient;
    logic               saturated;
    logic               divide_by_zero;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [FIELD_W-1:0] pwdata;
    logic [FIELD_W-1:0] prdata;
    logic               pready;

    // testbench copy of the multiplier register
    logic [FIELD_W-1:0] mult_shadow;
    quot_t              pending_quots[$];
    int                 fail_count;
    bit                 idle_on;

    ceil_mul_div_saturating dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .value(value), .divisor(divisor),
        .out_valid(out_valid), .out_stall(out_stall), .quotient(quotient),
        .saturated(saturated), .divide_by_zero(divide_by_zero),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Predict the ceiling quotient; the 128-bit product is exact in SV arithmetic.
    function automatic quot_t ceil_quot(logic [FIELD_W-1:0] v, logic [FIELD_W-1:0] d,
                                        logic [FIELD_W-1:0] m);
        logic [2*W-1:0] prod;
        logic [2*W-1:0] q;
        logic [2*W-1:0] r;
        logic [W-1:0]   all_ones;
        quot_t          res;
        all_ones = '1;
        res = '0;
        if (d[W-1:0] == '0)
        begin
            res.divide_by_zero = 1'b1;
            return res;
        end
        prod = {{W{1'b0}}, v[W-1:0]} * {{W{1'b0}}, m[W-1:0]};
        q = prod / {{W{1'b0}}, d[W-1:0]};
        r = prod % {{W{1'b0}}, d[W-1:0]};
        if (r != '0)
            q = q + 1'b1;
        if (q > {{W{1'b0}}, all_ones})
        begin
            res.quotient  = FIELD_W'(all_ones);
            res.saturated = 1'b1;
        end
        else
            res.quotient = FIELD_W'(q[W-1:0]);
        return res;
    endfunction

    // Send one transaction; hold valid across back-to-back sends.
    task automatic send_item(logic [FIELD_W-1:0] v, logic [FIELD_W-1:0] d);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        divisor  <= d;
        pending_quots.push_back(ceil_quot(v, d, mult_shadow));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_quots.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    // APB write: setup cycle then access cycle; pready is always high.
    task automatic write_mult(logic [FIELD_W-1:0] m);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MULTIPLIER;
        pwdata  <= m;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mult_shadow = m;
    endtask

    function automatic logic [FIELD_W-1:0] rand64();
        logic [FIELD_W-1:0] x;
        x = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: x = x >> $urandom_range(1, 63);
            1: x = 64'(0) | $urandom_range(0, 3);
            2: x = ~(64'(0) | $urandom_range(0, 3));
            default: ;
        endcase
        return x;
    endfunction

    task automatic test_directed;
        logic [FIELD_W-1:0] ones;
        ones = '1;
        // reset multiplier of one: plain ceiling division
        send_item(64'd0, 64'd1);
        send_item(ones, 64'd1);
        send_item(64'd7, 64'd2);
        send_item(64'd5, 64'd0);
        send_item(ones, 64'd0);
        write_mult(ones);
        send_item(ones, ones);
        send_item(ones, 64'd1);
        send_item(64'd1, 64'd1);
        send_item(64'd2, ones);
        send_item(ones, ones - 1);
        send_item(64'd3, 64'd0);
        // multiplier of two: the doubled all-ones value divides exactly, so no rounding
        write_mult(64'd2);
        send_item(ones, 64'd2);
        send_item(ones, 64'd3);
        write_mult(64'd0);
        send_item(ones, 64'd7);
        send_item(64'd0, 64'd0);
        write_mult(64'h8000_0000_0000_0000);
        send_item(64'd2, 64'd1);
        send_item(64'd3, 64'd2);
        send_item(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    endtask

    task automatic test_random(int n, bit idle);
        idle_on = idle;
        for (int i = 0; i < n; i++)
        begin
            if (i % 300 == 299)
                write_mult(rand64());
            send_item(rand64(), ($urandom_range(0, 19) == 0) ? 64'd0 : rand64());
        end
    endtask

    // Check each result against the oldest prediction.
    always @(posedge clk)
    begin
        quot_t exp_q;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_quots.size() == 0)
            begin
                $display("%0t: unexpected result quotient=%h", $time, quotient);
                fail_count++;
            end
            else
            begin
                exp_q = pending_quots.pop_front();
                if (quotient !== exp_q.quotient)
                begin
                    $display("%0t: quotient expected %h actual %h",
                             $time, exp_q.quotient, quotient);
                    fail_count++;
                end
                if (saturated !== exp_q.saturated)
                begin
                    $display("%0t: saturated expected %b actual %b",
                             $time, exp_q.saturated, saturated);
                    fail_count++;
                end
                if (divide_by_zero !== exp_q.divide_by_zero)
                begin
                    $display("%0t: divide_by_zero expected %b actual %b",
                             $time, exp_q.divide_by_zero, divide_by_zero);
                    fail_count++;
                end
            end
        end
    end

    // Stall the output in random bursts while idling is enabled.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        value       = '0;
        divisor     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        mult_shadow = MULT_RESET;
        fail_count  = 0;
        idle_on     = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(1500, 1'b1);
        // last stretch runs at full rate with no idling
        test_random(330, 1'b0);
        drain();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire
